### rtl/ptrp_pkg.sv
package ptrp_pkg;

  // Table depth bound; the record index saturates below it (and at the 7-bit port limit).
  localparam int MaxRecords = 128;
  localparam int CountLimitInt = ((MaxRecords - 1) > 127) ? 127 : (MaxRecords - 1);
  localparam logic [6:0] CountLimit = 7'(CountLimitInt);

  typedef enum logic [1:0] {
    KIND_NAME = 2'd0,
    KIND_LAST = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  name_byte;
    logic [31:0] extent_lba;
    logic [15:0] parent_number;
    logic [7:0]  name_length;
    logic [6:0]  record_index;
  } res_t;

endpackage

### rtl/path_table_record_parser.sv
// Little-endian ISO 9660 path table parser. Feed the table one byte per beat;
// assert table_start_i on the first byte of a table to restart the parser.
// Each beat is taken unless in_stall_o is high, so a full byte per clock is sustained
// whenever the result side keeps up. Each name byte produces one result beat
// (kind 0), the last name byte of a record produces a kind 1 beat carrying the
// extent LBA, parent number, name length and record index, and a zero length
// byte produces one kind 2 end-of-table beat; header, extended attribute and
// pad bytes produce nothing. Each result is registered into a two-entry output
// buffer when its byte is taken; the buffer decouples the sides: the input
// stalls only when both entries hold results that have not been taken yet.
module path_table_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        table_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  name_byte_o,
  output logic [31:0] extent_lba_o,
  output logic [15:0] parent_number_o,
  output logic [7:0]  name_length_o,
  output logic [6:0]  record_index_o
);
  import ptrp_pkg::*;

  logic accept;
  logic res_valid;
  logic full;
  res_t res;
  res_t out_res;

  // full comes from a register, so stall never waits on the output side
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  ptrp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .table_start_i (table_start_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  ptrp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign kind_o          = out_res.kind;
  assign name_byte_o     = out_res.name_byte;
  assign extent_lba_o    = out_res.extent_lba;
  assign parent_number_o = out_res.parent_number;
  assign name_length_o   = out_res.name_length;
  assign record_index_o  = out_res.record_index;

endmodule

### rtl/ptrp_parser.sv
module ptrp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  input  logic           table_start_i,
  output logic           res_valid_o,
  output ptrp_pkg::res_t res_o
);
  import ptrp_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN    = 3'd0,
    PH_EXT    = 3'd1,
    PH_LBA    = 3'd2,
    PH_PARENT = 3'd3,
    PH_NAME   = 3'd4,
    PH_PAD    = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d, phase_eff;
  logic [7:0]  offset_q, offset_d, offset_eff;
  logic [7:0]  len_q, len_d;
  logic [31:0] lba_q, lba_d;
  logic [15:0] parent_q, parent_d;
  logic [6:0]  count_q, count_d, count_eff;
  logic        done_q, done_d;
  logic        res_valid;
  res_t        res;

  always_comb begin
    // A table start wipes the parser before the byte is looked at.
    phase_eff  = table_start_i ? PH_LEN : phase_q;
    offset_eff = table_start_i ? 8'd0 : offset_q;
    count_eff  = table_start_i ? 7'd0 : count_q;
    phase_d    = phase_eff;
    offset_d   = offset_eff;
    len_d      = table_start_i ? 8'd0 : len_q;
    lba_d      = table_start_i ? 32'd0 : lba_q;
    parent_d   = table_start_i ? 16'd0 : parent_q;
    count_d    = count_eff;
    done_d     = table_start_i ? 1'b0 : done_q;
    res_valid  = 1'b0;
    res        = '{kind: KIND_NAME, name_byte: 8'd0, extent_lba: 32'd0,
                   parent_number: 16'd0, name_length: 8'd0, record_index: count_eff};
    if (table_start_i || !done_q) begin
      case (phase_eff)
        PH_EXT: begin
          phase_d  = PH_LBA;
          offset_d = 8'd0;
          lba_d    = 32'd0;
        end
        PH_LBA: begin
          lba_d    = lba_d | (32'(data_byte_i) << {offset_eff[1:0], 3'b000});
          offset_d = offset_eff + 8'd1;
          if (offset_eff == 8'd3) begin
            phase_d  = PH_PARENT;
            offset_d = 8'd0;
            parent_d = 16'd0;
          end
        end
        PH_PARENT: begin
          parent_d = parent_d | (16'(data_byte_i) << {offset_eff[0], 3'b000});
          offset_d = offset_eff + 8'd1;
          if (offset_eff == 8'd1) begin
            phase_d  = PH_NAME;
            offset_d = 8'd0;
          end
        end
        PH_NAME: begin
          res_valid     = 1'b1;
          res.name_byte = data_byte_i;
          if (({1'b0, offset_eff} + 9'd1) >= {1'b0, len_d}) begin
            res.kind          = KIND_LAST;
            res.extent_lba    = lba_d;
            res.parent_number = parent_d;
            res.name_length   = len_d;
            if (count_eff < CountLimit) count_d = count_eff + 7'd1;
            phase_d  = len_d[0] ? PH_PAD : PH_LEN;
            offset_d = 8'd0;
          end else begin
            offset_d = offset_eff + 8'd1;
          end
        end
        PH_PAD: begin
          phase_d = PH_LEN;
        end
        default: begin
          if (data_byte_i == 8'd0) begin
            done_d    = 1'b1;
            phase_d   = PH_LEN;
            res_valid = 1'b1;
            res.kind  = KIND_END;
          end else begin
            len_d    = data_byte_i;
            phase_d  = PH_EXT;
            offset_d = 8'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN;
      offset_q <= 8'd0;
      len_q    <= 8'd0;
      lba_q    <= 32'd0;
      parent_q <= 16'd0;
      count_q  <= 7'd0;
      done_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      len_q    <= len_d;
      lba_q    <= lba_d;
      parent_q <= parent_d;
      count_q  <= count_d;
      done_q   <= done_d;
    end
  end

  assign res_valid_o = accept_i && res_valid;
  assign res_o       = res;

  a_end_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res.kind == KIND_END |=> done_q)
    else $error("end of table did not latch done");
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !table_start_i && done_q |-> !res_valid_o)
    else $error("result after end of table");
  a_last_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res.kind == KIND_LAST |=> phase_q == PH_PAD || phase_q == PH_LEN)
    else $error("bad phase after record end");
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountLimit)
    else $error("record count beyond limit");

endmodule

### rtl/ptrp_skid.sv
module ptrp_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ptrp_pkg::res_t push_data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ptrp_pkg::res_t out_data_o
);
  import ptrp_pkg::*;

  res_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;
  logic       pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign full_o      = count_q == 2'd2;
  assign out_valid_o = count_q != 2'd0;
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      count_q <= count_q + 2'(push_i) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full buffer");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("buffer count out of range");

endmodule
